// ===== hw/rtl/rde_pkg.sv =====
// ----------------------------------------------------------------------------
// rde_pkg
// Shared types, widths and functions of the ray detector exit distance block.
// ----------------------------------------------------------------------------
package rde_pkg;

    localparam int COORD_W   = 32;
    localparam int DIR_W     = 16;
    localparam int EXT_W     = 31;
    localparam int LOC_W     = COORD_W + 1;   // localised coordinate
    localparam int DIR_FRAC  = 14;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    localparam int S_DATA_W  = 3 * COORD_W + 3 * DIR_W;
    localparam int POS_X_LO  = 0;
    localparam int POS_Y_LO  = COORD_W;
    localparam int POS_Z_LO  = 2 * COORD_W;
    localparam int DIR_X_LO  = 3 * COORD_W;
    localparam int DIR_Y_LO  = 3 * COORD_W + DIR_W;
    localparam int DIR_Z_LO  = 3 * COORD_W + 2 * DIR_W;

    localparam int HP_W   = 49;   // one product pos * dir
    localparam int H_W    = 50;   // px*dx + py*dy
    localparam int SQ1_W  = 65;   // square of a localised coordinate
    localparam int RR_W   = 62;   // radius squared
    localparam int DZ2_W  = 31;
    localparam int C_W    = 66;   // |px^2 + py^2 - r^2|
    localparam int A_W    = 29;   // 2^(2D) - dz^2 when positive
    localparam int PN_W   = 34;   // plane numerator magnitude
    localparam int Q_W    = 100;  // discriminant
    localparam int ROOT_W = Q_W / 2;
    localparam int REM_W  = ROOT_W + 2;
    localparam int NUM_W  = 66;   // dividend
    localparam int DEN_W  = 29;   // divisor
    localparam int QUO_W  = 41;   // quotient bits kept, clamp at 2^40
    localparam int T_W    = QUO_W + 1;

    localparam int SQRT_LAT = ROOT_W;
    localparam int DIV_LAT  = QUO_W + 2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic SHAPE_CYL  = 1'b0;
    localparam logic SHAPE_CUBE = 1'b1;

    localparam logic [EXT_W-1:0] EXT_RESET = EXT_W'(65536);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SHAPE = 3'd0,
        REG_ORG_X = 3'd1,
        REG_ORG_Y = 3'd2,
        REG_ORG_Z = 3'd3,
        REG_EXT_X = 3'd4,
        REG_EXT_Y = 3'd5,
        REG_EXT_Z = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic                      shape;
        logic signed [COORD_W-1:0] org_x;
        logic signed [COORD_W-1:0] org_y;
        logic signed [COORD_W-1:0] org_z;
        logic [EXT_W-1:0]          ext_x;
        logic [EXT_W-1:0]          ext_y;
        logic [EXT_W-1:0]          ext_z;
    } cfg_t;

    typedef struct packed {
        logic [PN_W-1:0]  mag;
        logic [DIR_W-1:0] den;
        logic             neg;
        logic             ok;
    } plane_t;

    typedef struct packed {
        logic signed [HP_W-1:0] hx;
        logic signed [HP_W-1:0] hy;
        logic [SQ1_W-1:0]       px2;
        logic [SQ1_W-1:0]       py2;
        logic [RR_W-1:0]        rr;
        logic [DZ2_W-1:0]       dz2;
        plane_t                 pl_x;
        plane_t                 pl_y;
        plane_t                 pl_z;
    } fq_t;

    typedef struct packed {
        logic signed [H_W-1:0] h;
        logic [A_W-1:0]        a;
        logic                  side_ok;
        plane_t                pl_x;
        plane_t                pl_y;
        plane_t                pl_z;
    } carry_t;

    typedef struct packed {
        logic full;
        logic not_empty;
    } q_stat_t;

    // Face plane terms: |(+ext or -ext) - p|, |d|, the sign of the distance and d != 0
    function automatic plane_t plane_calc(logic signed [LOC_W-1:0] p,
                                          logic signed [DIR_W-1:0] d,
                                          logic [EXT_W-1:0] ext);
        logic signed [PN_W:0] f;
        logic signed [PN_W:0] n;
        plane_t               r;
        f = $signed({{(PN_W + 1 - EXT_W){1'b0}}, ext});
        if (d[DIR_W-1]) begin
            f = -f;
        end
        n     = f - (PN_W + 1)'(p);
        r.mag = n[PN_W] ? PN_W'(-n) : PN_W'(n);
        r.neg = n[PN_W] ^ d[DIR_W-1];
        r.ok  = (d != '0);
        r.den = d[DIR_W-1] ? DIR_W'(-d) : DIR_W'(d);
        return r;
    endfunction

endpackage

// ===== hw/rtl/rde_fifo.sv =====
// ----------------------------------------------------------------------------
// rde_fifo
// Short queue that decouples the front end from the arithmetic back end.
// ----------------------------------------------------------------------------
module rde_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  rde_pkg::fq_t   push_item,
    input  logic           pop,
    output rde_pkg::fq_t   head,
    output rde_pkg::q_stat_t stat
);
    import rde_pkg::*;

    fq_t               mem_reg [0:QUEUE_DEPTH-1];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic              do_push;
    logic              do_pop;

    assign stat.full      = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.not_empty = (cnt_reg != '0);
    assign do_push        = push && !stat.full;
    assign do_pop         = pop && stat.not_empty;
    assign head           = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== hw/rtl/rde_front.sv =====
// ----------------------------------------------------------------------------
// rde_front
// Accepts rays, localises them and forms the first products and plane terms.
// ----------------------------------------------------------------------------
module rde_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  rde_pkg::cfg_t                 cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [rde_pkg::S_DATA_W-1:0]  in_data,
    output logic                          push,
    output rde_pkg::fq_t                  push_item,
    input  rde_pkg::q_stat_t              q_stat
);
    import rde_pkg::*;

    logic                      f1_valid_reg;
    logic signed [LOC_W-1:0]   f1_px_reg;
    logic signed [LOC_W-1:0]   f1_py_reg;
    logic signed [LOC_W-1:0]   f1_pz_reg;
    logic signed [DIR_W-1:0]   f1_dx_reg;
    logic signed [DIR_W-1:0]   f1_dy_reg;
    logic signed [DIR_W-1:0]   f1_dz_reg;
    logic                      f2_valid_reg;
    fq_t                       f2_item_reg;
    fq_t                       f2_item_next;
    logic                      ready2;
    logic [LOC_W-1:0]          ux;
    logic [LOC_W-1:0]          uy;
    logic signed [2*DIR_W-1:0] dz2s;

    assign ready2    = !f2_valid_reg || !q_stat.full;
    assign in_ready  = !f1_valid_reg || ready2;
    assign push      = f2_valid_reg && !q_stat.full;
    assign push_item = f2_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                f1_valid_reg <= in_valid;
            end
            if (ready2) begin
                f2_valid_reg <= f1_valid_reg;
            end
        end
    end

    // Localise to the detector origin
    always_ff @(posedge aclk) begin
        if (in_ready) begin
            f1_px_reg <= LOC_W'($signed(in_data[POS_X_LO +: COORD_W])) - LOC_W'(cfg.org_x);
            f1_py_reg <= LOC_W'($signed(in_data[POS_Y_LO +: COORD_W])) - LOC_W'(cfg.org_y);
            f1_pz_reg <= LOC_W'($signed(in_data[POS_Z_LO +: COORD_W])) - LOC_W'(cfg.org_z);
            f1_dx_reg <= $signed(in_data[DIR_X_LO +: DIR_W]);
            f1_dy_reg <= $signed(in_data[DIR_Y_LO +: DIR_W]);
            f1_dz_reg <= $signed(in_data[DIR_Z_LO +: DIR_W]);
        end
    end

    always_comb begin
        ux   = f1_px_reg[LOC_W-1] ? LOC_W'(-f1_px_reg) : LOC_W'(f1_px_reg);
        uy   = f1_py_reg[LOC_W-1] ? LOC_W'(-f1_py_reg) : LOC_W'(f1_py_reg);
        dz2s = f1_dz_reg * f1_dz_reg;
        f2_item_next.hx   = HP_W'(f1_px_reg) * HP_W'(f1_dx_reg);
        f2_item_next.hy   = HP_W'(f1_py_reg) * HP_W'(f1_dy_reg);
        f2_item_next.px2  = SQ1_W'(ux) * SQ1_W'(ux);
        f2_item_next.py2  = SQ1_W'(uy) * SQ1_W'(uy);
        f2_item_next.rr   = RR_W'(cfg.ext_x) * RR_W'(cfg.ext_x);
        f2_item_next.dz2  = dz2s[DZ2_W-1:0];
        f2_item_next.pl_x = plane_calc(f1_px_reg, f1_dx_reg, cfg.ext_x);
        f2_item_next.pl_y = plane_calc(f1_py_reg, f1_dy_reg, cfg.ext_y);
        f2_item_next.pl_z = plane_calc(f1_pz_reg, f1_dz_reg, cfg.ext_z);
    end

    always_ff @(posedge aclk) begin
        if (ready2) begin
            f2_item_reg <= f2_item_next;
        end
    end

endmodule

// ===== hw/rtl/rde_sqrt.sv =====
// ----------------------------------------------------------------------------
// rde_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module rde_sqrt (
    input  logic                         aclk,
    input  logic                         en,
    input  logic [rde_pkg::Q_W-1:0]      q_in,
    output logic [rde_pkg::ROOT_W-1:0]   root
);
    import rde_pkg::*;

    logic [REM_W-1:0]  r_reg [0:SQRT_LAT-2];
    logic [Q_W-1:0]    q_reg [0:SQRT_LAT-2];
    logic [ROOT_W-1:0] s_reg [0:SQRT_LAT-1];

    for (genvar k = 0; k < SQRT_LAT; k++) begin : g_stage
        localparam int HI = Q_W - 1 - 2 * k;
        logic [REM_W-1:0]  r_p;
        logic [ROOT_W-1:0] s_p;
        logic [Q_W-1:0]    q_p;
        logic [1:0]        pair;
        logic [REM_W+1:0]  pre;
        logic [REM_W+1:0]  trial;
        logic [REM_W+1:0]  diff;
        logic              ge;

        if (k == 0) begin : g_first
            assign r_p = '0;
            assign s_p = '0;
            assign q_p = q_in;
        end else begin : g_next
            assign r_p = r_reg[k-1];
            assign s_p = s_reg[k-1];
            assign q_p = q_reg[k-1];
        end

        assign pair = q_p[HI -: 2];

        always_comb begin
            pre   = {r_p, pair};
            trial = {2'b00, s_p, 2'b01};
            ge    = (pre >= trial);
            diff  = pre - trial;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                s_reg[k] <= {s_p[ROOT_W-2:0], ge};
            end
        end

        if (k < SQRT_LAT - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    r_reg[k] <= ge ? diff[REM_W-1:0] : pre[REM_W-1:0];
                    q_reg[k] <= q_p;
                end
            end
        end
    end

    assign root = s_reg[SQRT_LAT-1];

endmodule

// ===== hw/rtl/rde_div.sv =====
// ----------------------------------------------------------------------------
// rde_div
// Pipelined restoring divider, one quotient bit per stage, clamped at 2^40.
// ----------------------------------------------------------------------------
module rde_div (
    input  logic                               aclk,
    input  logic                               en,
    input  logic [rde_pkg::NUM_W-1:0]          num,
    input  logic [rde_pkg::DEN_W-1:0]          den,
    input  logic                               neg,
    output logic signed [rde_pkg::T_W-1:0]     res
);
    import rde_pkg::*;

    localparam logic [QUO_W-1:0] BIG = QUO_W'(1) << (QUO_W - 1);

    logic [DEN_W-1:0]     r_reg   [0:QUO_W-1];
    logic [DEN_W-1:0]     d_reg   [0:QUO_W-1];
    logic [QUO_W-1:0]     n_reg   [0:QUO_W-1];
    logic [QUO_W-1:0]     q_reg   [0:QUO_W];
    logic                 neg_reg [0:QUO_W];
    logic                 sat_reg [0:QUO_W];
    logic signed [T_W-1:0] res_reg;
    logic [QUO_W-1:0]     mag;

    // Quotient at or above 2^41 saturates outright
    always_ff @(posedge aclk) begin
        if (en) begin
            sat_reg[0] <= (DEN_W'(num[NUM_W-1:QUO_W]) >= den);
            r_reg[0]   <= DEN_W'(num[NUM_W-1:QUO_W]);
            n_reg[0]   <= num[QUO_W-1:0];
            d_reg[0]   <= den;
            q_reg[0]   <= '0;
            neg_reg[0] <= neg;
        end
    end

    for (genvar k = 1; k <= QUO_W; k++) begin : g_stage
        localparam int J = QUO_W - k;
        logic [DEN_W:0]   t;
        logic [DEN_W:0]   diff;
        logic             ge;
        logic [QUO_W-1:0] qn;

        always_comb begin
            t     = {r_reg[k-1], n_reg[k-1][J]};
            ge    = (t >= {1'b0, d_reg[k-1]});
            diff  = t - {1'b0, d_reg[k-1]};
            qn    = q_reg[k-1];
            qn[J] = ge;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                q_reg[k]   <= qn;
                neg_reg[k] <= neg_reg[k-1];
                sat_reg[k] <= sat_reg[k-1];
            end
        end

        if (k < QUO_W) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    r_reg[k] <= ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];
                    n_reg[k] <= n_reg[k-1];
                    d_reg[k] <= d_reg[k-1];
                end
            end
        end
    end

    assign mag = (sat_reg[QUO_W] || (q_reg[QUO_W] > BIG)) ? BIG : q_reg[QUO_W];

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= neg_reg[QUO_W] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        end
    end

    assign res = res_reg;

endmodule

// ===== hw/rtl/rde_back.sv =====
// ----------------------------------------------------------------------------
// rde_back
// Arithmetic back end: discriminant, root, three divisions, minimum, clamp.
// ----------------------------------------------------------------------------
module rde_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  rde_pkg::cfg_t                  cfg,
    input  rde_pkg::q_stat_t               q_stat,
    input  rde_pkg::fq_t                   q_head,
    output logic                           q_pop,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [rde_pkg::COORD_W-1:0]    m_distance,
    output logic                           m_no_hit,
    output logic                           m_clipped
);
    import rde_pkg::*;

    localparam logic [DZ2_W-1:0] A_ONE = DZ2_W'(1) << (2 * DIR_FRAC);
    localparam logic signed [T_W-1:0] T_MAX = T_W'(2147483647);
    localparam logic signed [T_W-1:0] T_MIN = -(T_W'(1) << 31);

    logic en;

    // B1
    logic             b1_valid_reg;
    carry_t           b1_carry_reg;
    logic [C_W-1:0]   b1_cmag_reg;
    logic             b1_cneg_reg;
    carry_t           b1_carry_next;
    logic [C_W-1:0]   pp;
    logic [C_W-1:0]   rr;
    // B2
    logic             b2_valid_reg;
    carry_t           b2_carry_reg;
    logic             b2_cneg_reg;
    logic [49:0]      b2_pll_reg;
    logic [48:0]      b2_plh_reg;
    logic [47:0]      b2_phh_reg;
    logic [50:0]      b2_c0a_reg;
    logic [50:0]      b2_c1a_reg;
    logic [50:0]      b2_c2a_reg;
    logic [HP_W-1:0]  ha;
    // B3
    logic             b3_valid_reg;
    carry_t           b3_carry_reg;
    logic             b3_cneg_reg;
    logic [97:0]      b3_h2_reg;
    logic [94:0]      b3_acm_reg;
    // B4
    logic             b4_valid_reg;
    carry_t           b4_carry_reg;
    carry_t           b4_carry_next;
    logic [Q_W-1:0]   b4_q_reg;
    logic [Q_W-1:0]   h2e;
    logic [Q_W-1:0]   acme;
    // root line
    logic             sq_vld_reg   [0:SQRT_LAT-1];
    carry_t           sq_carry_reg [0:SQRT_LAT-1];
    logic [ROOT_W-1:0] root;
    // B5
    logic             b5_valid_reg;
    logic [2:0]       b5_ok_reg;
    logic [NUM_W-1:0] b5_num_reg [0:2];
    logic [DEN_W-1:0] b5_den_reg [0:2];
    logic             b5_neg_reg [0:2];
    carry_t           sc;
    logic signed [H_W+1:0] snum;
    logic [H_W:0]     smag;
    // divide line
    logic             dv_vld_reg [0:DIV_LAT-1];
    logic [2:0]       dv_ok_reg  [0:DIV_LAT-1];
    logic signed [T_W-1:0] cand [0:2];
    // minimum and output
    logic             mn_valid_reg;
    logic             mn_have_reg;
    logic signed [T_W-1:0] mn_best_reg;
    logic             mn_have_next;
    logic signed [T_W-1:0] mn_best_next;
    logic             out_valid_reg;
    logic [COORD_W-1:0] out_dist_reg;
    logic             out_no_hit_reg;
    logic             out_clip_reg;

    // Whole back end moves together; hold while the result waits
    assign en    = !out_valid_reg || m_ready;
    assign q_pop = en && q_stat.not_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            b3_valid_reg  <= 1'b0;
            b4_valid_reg  <= 1'b0;
            b5_valid_reg  <= 1'b0;
            mn_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < SQRT_LAT; i++) begin
                sq_vld_reg[i] <= 1'b0;
            end
            for (int i = 0; i < DIV_LAT; i++) begin
                dv_vld_reg[i] <= 1'b0;
            end
        end else if (en) begin
            b1_valid_reg  <= q_stat.not_empty;
            b2_valid_reg  <= b1_valid_reg;
            b3_valid_reg  <= b2_valid_reg;
            b4_valid_reg  <= b3_valid_reg;
            sq_vld_reg[0] <= b4_valid_reg;
            for (int i = 1; i < SQRT_LAT; i++) begin
                sq_vld_reg[i] <= sq_vld_reg[i-1];
            end
            b5_valid_reg  <= sq_vld_reg[SQRT_LAT-1];
            dv_vld_reg[0] <= b5_valid_reg;
            for (int i = 1; i < DIV_LAT; i++) begin
                dv_vld_reg[i] <= dv_vld_reg[i-1];
            end
            mn_valid_reg  <= dv_vld_reg[DIV_LAT-1];
            out_valid_reg <= mn_valid_reg;
        end
    end

    // B1: sum the products, sign of c, axial term a
    always_comb begin
        pp = C_W'(q_head.px2) + C_W'(q_head.py2);
        rr = C_W'(q_head.rr);
        b1_carry_next.h       = H_W'($signed(q_head.hx)) + H_W'($signed(q_head.hy));
        b1_carry_next.side_ok = (q_head.dz2 < A_ONE);
        b1_carry_next.a       = A_W'(A_ONE - q_head.dz2);
        b1_carry_next.pl_x    = q_head.pl_x;
        b1_carry_next.pl_y    = q_head.pl_y;
        b1_carry_next.pl_z    = q_head.pl_z;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b1_carry_reg <= b1_carry_next;
            b1_cneg_reg  <= (pp < rr);
            b1_cmag_reg  <= (pp < rr) ? rr - pp : pp - rr;
        end
    end

    // B2: partial products of h^2 and a*c
    assign ha = b1_carry_reg.h[H_W-1] ? HP_W'(-b1_carry_reg.h) : HP_W'(b1_carry_reg.h);

    always_ff @(posedge aclk) begin
        if (en) begin
            b2_carry_reg <= b1_carry_reg;
            b2_cneg_reg  <= b1_cneg_reg;
            b2_pll_reg   <= 50'(ha[24:0]) * 50'(ha[24:0]);
            b2_plh_reg   <= 49'(ha[24:0]) * 49'(ha[48:25]);
            b2_phh_reg   <= 48'(ha[48:25]) * 48'(ha[48:25]);
            b2_c0a_reg   <= 51'(b1_cmag_reg[21:0]) * 51'(b1_carry_reg.a);
            b2_c1a_reg   <= 51'(b1_cmag_reg[43:22]) * 51'(b1_carry_reg.a);
            b2_c2a_reg   <= 51'(b1_cmag_reg[65:44]) * 51'(b1_carry_reg.a);
        end
    end

    // B3: assemble the two wide products
    always_ff @(posedge aclk) begin
        if (en) begin
            b3_carry_reg <= b2_carry_reg;
            b3_cneg_reg  <= b2_cneg_reg;
            b3_h2_reg    <= (98'(b2_phh_reg) << 50) + (98'(b2_plh_reg) << 26)
                            + 98'(b2_pll_reg);
            b3_acm_reg   <= (95'(b2_c2a_reg) << 44) + (95'(b2_c1a_reg) << 22)
                            + 95'(b2_c0a_reg);
        end
    end

    // B4: discriminant; drop the side wall when it is negative
    assign h2e  = Q_W'(b3_h2_reg);
    assign acme = Q_W'(b3_acm_reg);

    always_comb begin
        b4_carry_next = b3_carry_reg;
        if (!b3_cneg_reg) begin
            b4_carry_next.side_ok = b3_carry_reg.side_ok && (h2e >= acme);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b4_carry_reg <= b4_carry_next;
            if (b3_cneg_reg) begin
                b4_q_reg <= h2e + acme;
            end else begin
                b4_q_reg <= h2e - acme;
            end
        end
    end

    rde_sqrt u_sqrt (
        .aclk (aclk),
        .en   (en),
        .q_in (b4_q_reg),
        .root (root)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_carry_reg[0] <= b4_carry_reg;
            for (int i = 1; i < SQRT_LAT; i++) begin
                sq_carry_reg[i] <= sq_carry_reg[i-1];
            end
        end
    end

    // B5: side numerator, divider operand selection by shape
    assign sc   = sq_carry_reg[SQRT_LAT-1];
    assign snum = (H_W + 2)'($signed({1'b0, root})) - (H_W + 2)'(sc.h);
    assign smag = snum[H_W+1] ? (H_W + 1)'(-snum) : (H_W + 1)'(snum);

    always_ff @(posedge aclk) begin
        if (en) begin
            if (cfg.shape == SHAPE_CYL) begin
                b5_num_reg[0] <= NUM_W'({smag, DIR_FRAC'(0)});
                b5_den_reg[0] <= sc.a;
                b5_neg_reg[0] <= snum[H_W+1];
                b5_ok_reg     <= {sc.pl_z.ok, 1'b0, sc.side_ok};
            end else begin
                b5_num_reg[0] <= NUM_W'({sc.pl_x.mag, DIR_FRAC'(0)});
                b5_den_reg[0] <= DEN_W'(sc.pl_x.den);
                b5_neg_reg[0] <= sc.pl_x.neg;
                b5_ok_reg     <= {sc.pl_z.ok, sc.pl_y.ok, sc.pl_x.ok};
            end
            b5_num_reg[1] <= NUM_W'({sc.pl_y.mag, DIR_FRAC'(0)});
            b5_den_reg[1] <= DEN_W'(sc.pl_y.den);
            b5_neg_reg[1] <= sc.pl_y.neg;
            b5_num_reg[2] <= NUM_W'({sc.pl_z.mag, DIR_FRAC'(0)});
            b5_den_reg[2] <= DEN_W'(sc.pl_z.den);
            b5_neg_reg[2] <= sc.pl_z.neg;
        end
    end

    for (genvar u = 0; u < 3; u++) begin : g_div
        rde_div u_div (
            .aclk (aclk),
            .en   (en),
            .num  (b5_num_reg[u]),
            .den  (b5_den_reg[u]),
            .neg  (b5_neg_reg[u]),
            .res  (cand[u])
        );
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dv_ok_reg[0] <= b5_ok_reg;
            for (int i = 1; i < DIV_LAT; i++) begin
                dv_ok_reg[i] <= dv_ok_reg[i-1];
            end
        end
    end

    // Minimum over the candidates that apply
    always_comb begin
        mn_have_next = 1'b0;
        mn_best_next = '0;
        for (int u = 0; u < 3; u++) begin
            if (dv_ok_reg[DIV_LAT-1][u] && (!mn_have_next || (cand[u] < mn_best_next))) begin
                mn_best_next = cand[u];
                mn_have_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mn_have_reg <= mn_have_next;
            mn_best_reg <= mn_best_next;
        end
    end

    // Output register: infinity flag and saturation
    always_ff @(posedge aclk) begin
        if (en) begin
            out_no_hit_reg <= !mn_have_reg;
            if (!mn_have_reg) begin
                out_dist_reg <= COORD_W'(T_MAX);
                out_clip_reg <= 1'b0;
            end else if (mn_best_reg > T_MAX) begin
                out_dist_reg <= COORD_W'(T_MAX);
                out_clip_reg <= 1'b1;
            end else if (mn_best_reg < T_MIN) begin
                out_dist_reg <= COORD_W'(T_MIN);
                out_clip_reg <= 1'b1;
            end else begin
                out_dist_reg <= mn_best_reg[COORD_W-1:0];
                out_clip_reg <= 1'b0;
            end
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_distance = out_dist_reg;
    assign m_no_hit   = out_no_hit_reg;
    assign m_clipped  = out_clip_reg;

endmodule

// ===== hw/rtl/ray_detector_exit_distance_top.sv =====
// ----------------------------------------------------------------------------
// ray_detector_exit_distance_top
// Distance along a ray to the boundary of a cylinder or cuboid detector.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle while m_ is not stalled, set by
//   the fully pipelined root (50 stages, one bit each) and the three
//   dividers (43 stages each).
// Back-pressure on m_ holds the whole back end; a two-entry queue lets the
//   front keep taking transactions meanwhile.
// Reset: synchronous, active low; clears all valids, the queue and the
//   configuration (cylinder, origin 0, extents 1.0). No clearing pass.
module ray_detector_exit_distance_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write port
    input  logic                              cfg_wr_en,
    input  logic [rde_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rde_pkg::CFG_DAT_W-1:0]     cfg_wdata,
    // ray input
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // pos_x[31:0], pos_y[63:32], pos_z[95:64],
    // dir_x[111:96], dir_y[127:112], dir_z[143:128]
    input  logic [rde_pkg::S_DATA_W-1:0]      s_tdata,
    // result output
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // distance[31:0]
    output logic [rde_pkg::COORD_W-1:0]       m_tdata,
    // no_hit[0], clipped[1]
    output logic [1:0]                        m_tuser
);
    import rde_pkg::*;

    cfg_t    cfg_reg;
    logic    push;
    fq_t     push_item;
    fq_t     q_head;
    logic    q_pop;
    q_stat_t q_stat;

    // Configuration registers; write only while the block is idle (unenforced)
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.shape <= SHAPE_CYL;
            cfg_reg.org_x <= '0;
            cfg_reg.org_y <= '0;
            cfg_reg.org_z <= '0;
            cfg_reg.ext_x <= EXT_RESET;
            cfg_reg.ext_y <= EXT_RESET;
            cfg_reg.ext_z <= EXT_RESET;
        end else if (cfg_wr_en) begin
            unique case (reg_idx_t'(cfg_index))
                REG_SHAPE: cfg_reg.shape <= cfg_wdata[0];
                REG_ORG_X: cfg_reg.org_x <= $signed(cfg_wdata);
                REG_ORG_Y: cfg_reg.org_y <= $signed(cfg_wdata);
                REG_ORG_Z: cfg_reg.org_z <= $signed(cfg_wdata);
                REG_EXT_X: cfg_reg.ext_x <= cfg_wdata[EXT_W-1:0];
                REG_EXT_Y: cfg_reg.ext_y <= cfg_wdata[EXT_W-1:0];
                REG_EXT_Z: cfg_reg.ext_z <= cfg_wdata[EXT_W-1:0];
                default: begin
                    // drop writes to unknown indexes
                end
            endcase
        end
    end

    // Front: accept, localise, first products and plane terms
    rde_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .push      (push),
        .push_item (push_item),
        .q_stat    (q_stat)
    );

    // Queue between front and back
    rde_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (q_pop),
        .head      (q_head),
        .stat      (q_stat)
    );

    // Back: root, divisions, minimum and output register
    rde_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .q_stat     (q_stat),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_distance (m_tdata),
        .m_no_hit   (m_tuser[0]),
        .m_clipped  (m_tuser[1])
    );

endmodule

// ===== hw/rtl/rde_checker.sv =====
// ----------------------------------------------------------------------------
// rde_checker
// Port-level checks of the exit distance block, bound to the top level.
// ----------------------------------------------------------------------------
module rde_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // Reset empties the output stage
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A stalled result transaction holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Infinity reads as the top of the range and is never marked clipped
    a_no_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == 32'h7FFFFFFF && !m_tuser[1])
        else $error("no_hit result malformed");

    // A clipped distance sits at a range limit
    a_clip: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> (m_tdata == 32'h7FFFFFFF || m_tdata == 32'h80000000))
        else $error("clipped distance not at a limit");

endmodule

bind ray_detector_exit_distance_top rde_checker u_rde_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== tb/ray_detector_exit_distance_top_test.sv =====
// ----------------------------------------------------------------------------
// ray_detector_exit_distance_top_test
// Self-checking bench for the ray to detector boundary distance unit.
// Rays go in as bursts with random gaps while the result side stalls on a
// pattern of its own. Rays whose row holds no written expectation are run
// through a bit-exact predictor of the cylinder and cuboid arithmetic; the
// expected distance, no-hit and clip flags are matched in order to results.
// ----------------------------------------------------------------------------
module ray_detector_exit_distance_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rde_pkg::*;

    localparam int  RAND_RAYS  = 800;
    localparam int  DRAIN_WAIT = 150;    // comfortably above the pipeline latency
    localparam int  STALL_MAX  = 4000;   // cycles without any transaction
    localparam int  DFRAC      = 14;
    localparam int  UNIT_DIR   = 16384;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic [31:0] distance;
        logic        no_hit;
        logic        clipped;
    } exit_t;

    typedef struct {
        int      px, py, pz;
        shortint dx, dy, dz;
        bit      typed;        // expectation written in the row
        exit_t   res;
    } ray_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DAT_W-1:0]  cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [COORD_W-1:0]    m_tdata;
    logic [1:0]            m_tuser;

    // shadow of the detector registers
    logic                  det_shape;
    longint                det_org[3];
    longint                det_ext[3];

    exit_t                 pending_exits[$];
    int                    errors;
    int                    quiet_cycles;

    ray_detector_exit_distance_top i_dut (.*);

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // floor(mag * 2^D / den), magnitude held at 2^40
    function automatic wide_t scaled_quot(wide_t mag, wide_t den);
        wide_t r;
        r = (mag <<< DFRAC) / den;
        if (r > (wide_t'(1) <<< 40)) begin
            r = wide_t'(1) <<< 40;
        end
        return r;
    endfunction

    function automatic bit face_time(wide_t p, wide_t d, wide_t ext, output wide_t t);
        wide_t n;
        t = 0;
        if (d == 0) begin
            return 1'b0;
        end
        n = ((d > 0) ? ext : -ext) - p;
        t = scaled_quot((n < 0) ? -n : n, (d < 0) ? -d : d);
        if ((n < 0) != (d < 0)) begin
            t = -t;
        end
        return 1'b1;
    endfunction

    function automatic bit wall_time(wide_t px, wide_t py, wide_t dx, wide_t dy,
                                     wide_t dz, output wide_t t);
        wide_t a, h, c, q, s, cand, num;
        t = 0;
        a = (wide_t'(1) <<< (2 * DFRAC)) - dz * dz;
        if (a <= 0) begin
            return 1'b0;
        end
        h = px * dx + py * dy;
        c = px * px + py * py - wide_t'(det_ext[0]) * wide_t'(det_ext[0]);
        q = h * h - a * c;
        if (q < 0) begin
            return 1'b0;
        end
        s = 0;
        for (int b = 62; b >= 0; b--) begin
            cand = s | (wide_t'(1) <<< b);
            if (cand * cand <= q) begin
                s = cand;
            end
        end
        num = s - h;
        t = scaled_quot((num < 0) ? -num : num, a);
        if (num < 0) begin
            t = -t;
        end
        return 1'b1;
    endfunction

    function automatic exit_t exit_distance(int pos[3], shortint dir[3]);
        wide_t p[3], d[3], t, best;
        bit    found;
        exit_t r;
        found = 1'b0;
        best  = 0;
        for (int i = 0; i < 3; i++) begin
            p[i] = wide_t'(longint'(pos[i]) - det_org[i]);
            d[i] = wide_t'(dir[i]);
        end
        if (det_shape == SHAPE_CYL) begin
            if (wall_time(p[0], p[1], d[0], d[1], d[2], t)) begin
                best  = t;
                found = 1'b1;
            end
            if (face_time(p[2], d[2], wide_t'(det_ext[2]), t) && (!found || t < best)) begin
                best  = t;
                found = 1'b1;
            end
        end else begin
            for (int i = 0; i < 3; i++) begin
                if (face_time(p[i], d[i], wide_t'(det_ext[i]), t) && (!found || t < best)) begin
                    best  = t;
                    found = 1'b1;
                end
            end
        end
        r.no_hit  = !found;
        r.clipped = 1'b0;
        if (!found) begin
            r.distance = 32'h7FFF_FFFF;
        end else if (best > 64'sh7FFF_FFFF) begin
            r.distance = 32'h7FFF_FFFF;
            r.clipped  = 1'b1;
        end else if (best < -64'sh8000_0000) begin
            r.distance = 32'h8000_0000;
            r.clipped  = 1'b1;
        end else begin
            r.distance = best[31:0];
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Register writes and ray transactions
    // ------------------------------------------------------------------

    // Leave the write enable high; the caller drops it after the last write.
    task automatic write_reg(reg_idx_t idx, logic [31:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        case (idx)
            REG_SHAPE: det_shape  = value[0];
            REG_ORG_X: det_org[0] = longint'(signed'(value));
            REG_ORG_Y: det_org[1] = longint'(signed'(value));
            REG_ORG_Z: det_org[2] = longint'(signed'(value));
            REG_EXT_X: det_ext[0] = longint'(value[30:0]);
            REG_EXT_Y: det_ext[1] = longint'(value[30:0]);
            REG_EXT_Z: det_ext[2] = longint'(value[30:0]);
            default: ;
        endcase
    endtask

    task automatic set_detector(logic shape, int ox, int oy, int oz,
                                logic [30:0] ex, logic [30:0] ey, logic [30:0] ez);
        write_reg(REG_SHAPE, {31'd0, shape});
        write_reg(REG_ORG_X, ox);
        write_reg(REG_ORG_Y, oy);
        write_reg(REG_ORG_Z, oz);
        write_reg(REG_EXT_X, {1'b0, ex});
        write_reg(REG_EXT_Y, {1'b0, ey});
        write_reg(REG_EXT_Z, {1'b0, ez});
        cfg_wr_en <= 1'b0;
    endtask

    // Hold the ray until taken; the caller decides whether valid drops after.
    task automatic send_ray(ray_row_t row);
        int      pos[3];
        shortint dir[3];
        pos = '{row.px, row.py, row.pz};
        dir = '{row.dx, row.dy, row.dz};
        s_tvalid <= 1'b1;
        s_tdata  <= {row.dz, row.dy, row.dx, row.pz, row.py, row.px};
        do @(posedge aclk); while (!s_tready);
        pending_exits.push_back(row.typed ? row.res : exit_distance(pos, dir));
    endtask

    // Let every result come out and the pipe run dry before touching registers.
    task automatic drain();
        while (pending_exits.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    function automatic shortint rand_dir();
        case ($urandom_range(0, 9))
            0:       return 16'sd0;
            1:       return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
            default: return shortint'($urandom_range(0, 2 * UNIT_DIR)) - 16'sd16384;
        endcase
    endfunction

    // mostly near the detector, sometimes anywhere
    function automatic int rand_pos(int axis);
        if ($urandom_range(0, 3) == 0) begin
            return int'($urandom());
        end
        return int'(det_org[axis]) + int'($urandom_range(0, 1 << 20)) - (1 << 19);
    endfunction

    task automatic random_rays(int count);
        ray_row_t row;
        int       burst;
        row.typed = 1'b0;
        while (count > 0) begin
            burst = $urandom_range(1, 16);
            while (burst > 0 && count > 0) begin
                row.px = rand_pos(0);
                row.py = rand_pos(1);
                row.pz = rand_pos(2);
                row.dx = rand_dir();
                row.dy = rand_dir();
                row.dz = rand_dir();
                send_ray(row);
                burst--;
                count--;
            end
            if ($urandom_range(0, 2) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Directed rays, under the reset detector (unit cylinder at the origin)
    // ------------------------------------------------------------------
    localparam int N_DIRECTED = 14;
    ray_row_t directed[N_DIRECTED] = '{
        // straight up the axis to the top cap at 1.0
        '{0, 0, 0, 0, 0, 16384, 1'b1, '{32'h0001_0000, 1'b0, 1'b0}},
        // no direction at all: wall root lands at 1.0
        '{0, 0, 0, 0, 0, 0, 1'b1, '{32'h0001_0000, 1'b0, 1'b0}},
        // far off the axis, barely moving up from the bottom: cap beyond range
        '{32'h7FFF_FFFF, 0, 32'h8000_0000, 0, 0, 1, 1'b1, '{32'h7FFF_FFFF, 1'b0, 1'b1}},
        // cap far behind the start: clip below
        '{32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 0, 0, 1, 1'b1, '{32'h8000_0000, 1'b0, 1'b1}},
        '{0, 0, 0, 0, 0, -16384, 1'b0, '{0, 0, 0}},
        '{0, 0, 0, 16384, 0, 0, 1'b0, '{0, 0, 0}},
        '{0, 0, 0, -16384, 0, 0, 1'b0, '{0, 0, 0}},
        '{0, 0, 0, 0, 16384, 0, 1'b0, '{0, 0, 0}},
        '{0, 0, 0, 0, -16384, 0, 1'b0, '{0, 0, 0}},
        '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 11585, 11585, 0, 1'b0, '{0, 0, 0}},
        '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, -9459, -9459, -9459,
          1'b0, '{0, 0, 0}},
        // start outside, heading away: negative distance
        '{32'h0003_0000, 0, 0, 16384, 0, 0, 1'b0, '{0, 0, 0}},
        // non-unit direction
        '{32'h0000_8000, -32'sh0000_4000, 32'h0000_2000, 16384, 16384, -16384,
          1'b0, '{0, 0, 0}},
        '{-32'sh0000_8000, 32'h0000_C000, -32'sh0000_C000, -1, 1, -1, 1'b0, '{0, 0, 0}}
    };

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        ray_row_t blind;
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_SHAPE;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        errors    = 0;
        det_shape = SHAPE_CYL;
        det_org   = '{0, 0, 0};
        det_ext   = '{65536, 65536, 65536};
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            send_ray(directed[i]);
        end
        random_rays(RAND_RAYS / 5);
        drain();

        // cuboid off the origin; a ray with no direction reaches nothing
        set_detector(SHAPE_CUBE, 32'h0002_0000, -32'sh0001_8000, 32'h0000_4000,
                     31'h0002_0000, 31'h0000_8000, 31'h0001_0000);
        blind = '{0, 0, 0, 0, 0, 0, 1'b1, '{32'h7FFF_FFFF, 1'b1, 1'b0}};
        send_ray(blind);
        random_rays(RAND_RAYS / 5);
        drain();

        // extremes: cylinder with the largest radius and height at the corner
        set_detector(SHAPE_CYL, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                     31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        random_rays(RAND_RAYS / 10);
        drain();

        // degenerate: zero extents
        set_detector(SHAPE_CUBE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                     31'd0, 31'd0, 31'd0);
        random_rays(RAND_RAYS / 10);
        drain();
        set_detector(SHAPE_CYL, 0, 0, 0, 31'd0, 31'd0, 31'd0);
        random_rays(RAND_RAYS / 10);
        drain();

        // random detectors
        repeat (4) begin
            set_detector(1'($urandom_range(0, 1)), $urandom(), $urandom(), $urandom(),
                         31'($urandom_range(0, 1 << 20)), 31'($urandom_range(0, 1 << 20)),
                         31'($urandom()));
            random_rays(RAND_RAYS / 10);
            drain();
        end

        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: stall pattern, stepping through four modes as stall_tick counts cycles
    // ------------------------------------------------------------------
    logic [9:0] stall_tick;
    always @(posedge aclk) begin
        if (!aresetn) begin
            stall_tick <= '0;
            m_tready   <= 1'b0;
        end else begin
            stall_tick <= stall_tick + 1'b1;
            case (stall_tick[9:8])
                2'd0:    m_tready <= 1'b1;
                2'd1:    m_tready <= ($urandom_range(0, 3) != 0);
                2'd2:    m_tready <= (stall_tick[4:0] < 5'd20);
                default: m_tready <= ($urandom_range(0, 1) != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Check each result against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        exit_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_exits.size() == 0) begin
                $display("%0t: result with nothing expected: distance %h user %b",
                         $realtime, m_tdata, m_tuser);
                errors++;
            end else begin
                want = pending_exits.pop_front();
                if (m_tdata !== want.distance) begin
                    $display("%0t: distance expected %h actual %h",
                             $realtime, want.distance, m_tdata);
                    errors++;
                end
                if (m_tuser[0] !== want.no_hit) begin
                    $display("%0t: no_hit expected %b actual %b",
                             $realtime, want.no_hit, m_tuser[0]);
                    errors++;
                end
                if (m_tuser[1] !== want.clipped) begin
                    $display("%0t: clipped expected %b actual %b",
                             $realtime, want.clipped, m_tuser[1]);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: give up when nothing moves for too long
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_MAX) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

// ===== ray_detector_exit_distance_top.f =====
hw/rtl/rde_pkg.sv
hw/rtl/rde_fifo.sv
hw/rtl/rde_front.sv
hw/rtl/rde_sqrt.sv
hw/rtl/rde_div.sv
hw/rtl/rde_back.sv
hw/rtl/ray_detector_exit_distance_top.sv
hw/rtl/rde_checker.sv
tb/ray_detector_exit_distance_top_test.sv
